### hdl/dcqs_pkg.sv
`default_nettype none
package dcqs_pkg;

	localparam logic [1:0] OP_XFER  = 2'd0;
	localparam logic [1:0] OP_FILL  = 2'd1;
	localparam logic [1:0] OP_COPY  = 2'd2;
	localparam logic [1:0] OP_FLUSH = 2'd3;

	localparam logic [1:0] TARGET_VRAM = 2'd0;

	localparam logic [17:0] BOUNDARY_SPAN = 18'h20000;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  target;
		logic [15:0] dest;
		logic [22:0] source;
		logic [15:0] length;
		logic [7:0]  stride;
	} entry_t;

	typedef struct packed {
		logic accept;
		logic push;
		logic second;
		logic rd_issue;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic last;
		logic split;
		logic out_free;
	} dp_stat_t;

endpackage
`default_nettype wire

### hdl/dma_command_queue_split.sv
// Channel  Handshake            Payload
// req      req_valid/req_stall  opcode, target_memory, dest_address, source_address,
//                               length, stride
// cmd      cmd_valid/cmd_stall  command_kind, command_target, command_dest,
//                               command_source, command_length, command_stride,
//                               last_of_flush
//
// An enqueue registers the request, then writes one entry, or two when a transfer is split in two.
// A flush issues a registered read of the queue memory and loads the result into
// a single output register before the next read; cmd_stall holds the next read.
// A full queue is drained before the new entry is written.
// Reset clears the pointers, the fill count and the output valid; there is no
// clearing pass, and the queue accepts an item in the first cycle after reset.
`default_nettype none
module dma_command_queue_split #(
	parameter int QUEUE_DEPTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output      logic        req_stall,
	input  wire logic [1:0]  opcode,
	input  wire logic [1:0]  target_memory,
	input  wire logic [15:0] dest_address,
	input  wire logic [23:0] source_address,
	input  wire logic [15:0] length,
	input  wire logic [7:0]  stride,
	output      logic        cmd_valid,
	input  wire logic        cmd_stall,
	output      logic [1:0]  command_kind,
	output      logic [1:0]  command_target,
	output      logic [15:0] command_dest,
	output      logic [22:0] command_source,
	output      logic [15:0] command_length,
	output      logic [7:0]  command_stride,
	output      logic        last_of_flush
);
	import dcqs_pkg::*;

	ctrl_cmd_t ctrl_cmd;
	dp_stat_t  dp_stat;

	dcqs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_opcode (opcode),
		.stat       (dp_stat),
		.cmd        (ctrl_cmd),
		.req_stall  (req_stall)
	);

	dcqs_dp #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (ctrl_cmd),
		.stat           (dp_stat),
		.opcode         (opcode),
		.target_memory  (target_memory),
		.dest_address   (dest_address),
		.source_address (source_address),
		.length         (length),
		.stride         (stride),
		.cmd_stall      (cmd_stall),
		.cmd_valid      (cmd_valid),
		.command_kind   (command_kind),
		.command_target (command_target),
		.command_dest   (command_dest),
		.command_source (command_source),
		.command_length (command_length),
		.command_stride (command_stride),
		.last_of_flush  (last_of_flush)
	);

endmodule
`default_nettype wire

### hdl/dcqs_ram.sv
`default_nettype none
module dcqs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

### hdl/dcqs_ctrl.sv
`default_nettype none
module dcqs_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	input  wire logic [1:0]          req_opcode,
	input  wire dcqs_pkg::dp_stat_t  stat,
	output      dcqs_pkg::ctrl_cmd_t cmd,
	output      logic                req_stall
);
	import dcqs_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PUSH1 = 3'd1;
	localparam logic [2:0] S_PUSH2 = 3'd2;
	localparam logic [2:0] S_READ  = 3'd3;
	localparam logic [2:0] S_LOAD  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [2:0] ret_q;
	logic [2:0] ret_d;

	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					if (req_opcode == OP_FLUSH) begin
						ret_d = S_IDLE;
						if (!stat.empty) begin
							state_d = S_READ;
						end
					end else begin
						state_d = S_PUSH1;
					end
				end
			end
			S_PUSH1: begin
				if (stat.full) begin
					ret_d   = S_PUSH1;
					state_d = S_READ;
				end else begin
					cmd.push = 1'b1;
					state_d  = stat.split ? S_PUSH2 : S_IDLE;
				end
			end
			S_PUSH2: begin
				cmd.second = 1'b1;
				if (stat.full) begin
					ret_d   = S_PUSH2;
					state_d = S_READ;
				end else begin
					cmd.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_READ: begin
				if (stat.out_free) begin
					cmd.rd_issue = 1'b1;
					state_d      = S_LOAD;
				end
			end
			S_LOAD: begin
				cmd.load_out = 1'b1;
				state_d      = stat.last ? ret_q : S_READ;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	assign req_stall = (state_q != S_IDLE);

endmodule
`default_nettype wire

### hdl/dcqs_dp.sv
`default_nettype none
module dcqs_dp #(
	parameter int QUEUE_DEPTH = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire dcqs_pkg::ctrl_cmd_t cmd,
	output      dcqs_pkg::dp_stat_t  stat,
	input  wire logic [1:0]          opcode,
	input  wire logic [1:0]          target_memory,
	input  wire logic [15:0]         dest_address,
	input  wire logic [23:0]         source_address,
	input  wire logic [15:0]         length,
	input  wire logic [7:0]          stride,
	input  wire logic                cmd_stall,
	output      logic                cmd_valid,
	output      logic [1:0]          command_kind,
	output      logic [1:0]          command_target,
	output      logic [15:0]         command_dest,
	output      logic [22:0]         command_source,
	output      logic [15:0]         command_length,
	output      logic [7:0]          command_stride,
	output      logic                last_of_flush
);
	import dcqs_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	logic [1:0]  opcode_q;
	logic [1:0]  target_q;
	logic [15:0] dest_q;
	logic [23:0] source_q;
	logic [15:0] length_q;
	logic [7:0]  stride_q;

	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             cmd_valid_q;
	logic             last_q;
	entry_t           out_q;

	logic [17:0] limit;
	logic [16:0] half;
	logic        split;
	logic        upper;
	logic [23:0] raw_source;
	entry_t      wr_entry;
	entry_t      rd_entry;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			opcode_q <= opcode;
			target_q <= target_memory;
			dest_q   <= dest_address;
			source_q <= source_address;
			length_q <= length;
			stride_q <= stride;
		end
	end

	assign limit = BOUNDARY_SPAN - {1'b0, source_q[16:0]};
	assign half  = limit[17:1];
	assign split = (opcode_q == OP_XFER) && ({1'b0, length_q} > half);
	assign upper = split && !cmd.second;

	always_comb begin
		raw_source      = upper ? (source_q + {6'd0, limit}) : source_q;
		wr_entry.kind   = opcode_q;
		wr_entry.target = (opcode_q == OP_XFER) ? target_q : TARGET_VRAM;
		wr_entry.dest   = upper ? (dest_q + limit[15:0]) : dest_q;
		wr_entry.stride = stride_q;
		if (upper) begin
			wr_entry.length = length_q - half[15:0];
		end else if (split) begin
			wr_entry.length = half[15:0];
		end else begin
			wr_entry.length = length_q;
		end
		case (opcode_q)
			OP_XFER: wr_entry.source = raw_source[23:1];
			OP_FILL: wr_entry.source = {15'd0, raw_source[7:0]};
			default: wr_entry.source = {7'd0, raw_source[15:0]};
		endcase
	end

	dcqs_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.push),
		.waddr (wr_ptr_q),
		.wdata (wr_entry),
		.re    (cmd.rd_issue),
		.raddr (rd_ptr_q),
		.rdata (rd_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			count_q     <= '0;
			cmd_valid_q <= 1'b0;
		end else begin
			if (cmd.push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
				count_q  <= count_q + 1'b1;
			end else if (cmd.load_out) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
				count_q  <= count_q - 1'b1;
			end
			if (cmd.load_out) begin
				cmd_valid_q <= 1'b1;
			end else if (!cmd_stall) begin
				cmd_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q  <= rd_entry;
			last_q <= (count_q == CNT_ONE);
		end
	end

	assign stat.full     = (count_q == CNT_FULL);
	assign stat.empty    = (count_q == '0);
	assign stat.last     = (count_q == CNT_ONE);
	assign stat.split    = split;
	assign stat.out_free = !cmd_valid_q || !cmd_stall;

	assign cmd_valid      = cmd_valid_q;
	assign command_kind   = out_q.kind;
	assign command_target = out_q.target;
	assign command_dest   = out_q.dest;
	assign command_source = out_q.source;
	assign command_length = out_q.length;
	assign command_stride = out_q.stride;
	assign last_of_flush  = last_q;

endmodule
`default_nettype wire

### hdl/dcqs_chk.sv
`default_nettype none
module dcqs_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        cmd_valid,
	input wire logic        cmd_stall,
	input wire logic [1:0]  command_kind,
	input wire logic [1:0]  command_target,
	input wire logic [15:0] command_dest,
	input wire logic [22:0] command_source,
	input wire logic [15:0] command_length,
	input wire logic [7:0]  command_stride,
	input wire logic        last_of_flush
);
	import dcqs_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_stall |=> cmd_valid && $stable(command_kind)
			&& $stable(command_target) && $stable(command_dest)
			&& $stable(command_source) && $stable(command_length)
			&& $stable(command_stride) && $stable(last_of_flush))
		else $error("Stalled command changed.");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid |-> command_kind != OP_FLUSH)
		else $error("Flush code emitted as a command.");

	a_target: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && command_kind != OP_XFER |-> command_target == TARGET_VRAM)
		else $error("Fill or copy command has a non-VRAM target.");

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && command_kind == OP_FILL |-> command_source[22:8] == '0)
		else $error("Fill value wider than a byte.");

	a_copy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && command_kind == OP_COPY |-> command_source[22:16] == '0)
		else $error("Copy source wider than 16 bits.");

endmodule

bind dma_command_queue_split dcqs_chk u_dcqs_chk (.*);
`default_nettype wire

### verif/dma_command_queue_split_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module dma_command_queue_split_tb;
	import dcqs_pkg::*;

	localparam int QUEUE_DEPTH = 32;
	localparam int IDLE_PERCENT = 32;
	localparam int RANDOM_ITEMS = 440;

	typedef struct {
		logic [1:0]  op;
		logic [1:0]  target;
		logic [15:0] dest;
		logic [23:0] source;
		logic [15:0] len;
		logic [7:0]  step;
	} request_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  target;
		logic [15:0] dest;
		logic [22:0] source;
		logic [15:0] len;
		logic [7:0]  step;
		logic        last;
	} command_t;

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [1:0] opcode = '0;
	logic [1:0] target_memory = '0;
	logic [15:0] dest_address = '0;
	logic [23:0] source_address = '0;
	logic [15:0] length = '0;
	logic [7:0] stride = '0;
	logic cmd_valid;
	logic cmd_stall = 1'b0;
	logic [1:0] command_kind;
	logic [1:0] command_target;
	logic [15:0] command_dest;
	logic [22:0] command_source;
	logic [15:0] command_length;
	logic [7:0] command_stride;
	logic last_of_flush;

	request_t request_fifo[$];
	command_t queued_cmds[$];
	command_t expected_cmds[$];
	int unsigned accepted_reqs = 0;
	int unsigned mismatches = 0;

	wire calm = (accepted_reqs >= 180) && (accepted_reqs < 270);

	dma_command_queue_split #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.opcode(opcode),
		.target_memory(target_memory),
		.dest_address(dest_address),
		.source_address(source_address),
		.length(length),
		.stride(stride),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.command_kind(command_kind),
		.command_target(command_target),
		.command_dest(command_dest),
		.command_source(command_source),
		.command_length(command_length),
		.command_stride(command_stride),
		.last_of_flush(last_of_flush)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic emit_queued_cmds();
		command_t c;
		int n;
		n = queued_cmds.size();
		for (int i = 0; i < n; i++) begin
			c = queued_cmds[i];
			c.last = (i == n - 1);
			expected_cmds.push_back(c);
		end
		queued_cmds.delete();
	endtask

	task automatic enqueue_cmd(logic [1:0] kind, logic [1:0] target, logic [15:0] dest,
			logic [23:0] src, logic [15:0] len, logic [7:0] step);
		command_t c;
		if (queued_cmds.size() >= QUEUE_DEPTH)
			emit_queued_cmds();
		c.kind = kind;
		c.dest = dest;
		c.len = len;
		c.step = step;
		c.last = 1'b0;
		case (kind)
			OP_XFER: begin
				c.source = src[23:1];
				c.target = target;
			end
			OP_FILL: begin
				c.source = {15'd0, src[7:0]};
				c.target = TARGET_VRAM;
			end
			default: begin
				c.source = {7'd0, src[15:0]};
				c.target = TARGET_VRAM;
			end
		endcase
		queued_cmds.push_back(c);
	endtask

	task automatic predict_request(request_t r);
		logic [17:0] span_left;
		logic [16:0] half_words;
		logic [15:0] len;
		len = r.len;
		if (r.op == OP_FLUSH) begin
			emit_queued_cmds();
		end else begin
			if (r.op == OP_XFER) begin
				span_left = BOUNDARY_SPAN - {1'b0, r.source[16:0]};
				half_words = span_left[17:1];
				if ({1'b0, len} > half_words) begin
					enqueue_cmd(OP_XFER, r.target, r.dest + span_left[15:0],
						r.source + {6'd0, span_left}, len - half_words[15:0], r.step);
					len = half_words[15:0];
				end
			end
			enqueue_cmd(r.op, r.target, r.dest, r.source, len, r.step);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		request_t r;
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || !req_stall) begin
			if (req_valid)
				accepted_reqs++;
			if (request_fifo.size() > 0 && (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
				r = request_fifo.pop_front();
				predict_request(r);
				opcode <= r.op;
				target_memory <= r.target;
				dest_address <= r.dest;
				source_address <= r.source;
				length <= r.len;
				stride <= r.step;
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	task automatic report_mismatch(string what, command_t want, command_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t: %s", $realtime, what);
			$display("  expected kind %0d target %0d dest %h src %h len %h stride %h last %0d",
				want.kind, want.target, want.dest, want.source, want.len, want.step,
				want.last);
			$display("  got      kind %0d target %0d dest %h src %h len %h stride %h last %0d",
				got.kind, got.target, got.dest, got.source, got.len, got.step, got.last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		command_t got;
		command_t want;
		if (!arst_n) begin
			cmd_stall <= 1'b0;
		end else begin
			if (cmd_valid && !cmd_stall) begin
				got = {command_kind, command_target, command_dest, command_source,
					command_length, command_stride, last_of_flush};
				if (expected_cmds.size() == 0) begin
					report_mismatch("unexpected command", '0, got);
				end else begin
					want = expected_cmds.pop_front();
					if (got.kind !== want.kind || got.target !== want.target ||
							got.dest !== want.dest || got.source !== want.source ||
							got.len !== want.len || got.step !== want.step ||
							got.last !== want.last)
						report_mismatch("command mismatch", want, got);
				end
			end
			cmd_stall <= calm ? 1'b0 : ($urandom_range(99) < IDLE_PERCENT);
		end
	end

	function automatic request_t make_request(logic [1:0] op, logic [1:0] target,
			logic [15:0] dest, logic [23:0] src, logic [15:0] len, logic [7:0] step);
		request_t r;
		r.op = op;
		r.target = target;
		r.dest = dest;
		r.source = src;
		r.len = len;
		r.step = step;
		return r;
	endfunction

	function automatic request_t random_request(int flush_one_in);
		logic [1:0] op;
		logic [23:0] src;
		logic [15:0] len;
		if (flush_one_in > 0 && $urandom_range(flush_one_in - 1) == 0)
			op = OP_FLUSH;
		else
			op = 2'($urandom_range(2));
		src = 24'($urandom_range(24'hFFFFFF));
		if ($urandom_range(1))
			src[16:0] = 17'h1FFFF - 17'($urandom_range(80));
		len = $urandom_range(2) == 0 ? 16'($urandom_range(16'hFFFF)) : 16'($urandom_range(64));
		return make_request(op, 2'($urandom_range(3)), 16'($urandom_range(16'hFFFF)), src,
			len, 8'($urandom_range(8'hFF)));
	endfunction

	initial begin
		request_fifo.push_back(make_request(OP_FLUSH, 0, 0, 0, 0, 0));
		request_fifo.push_back(make_request(OP_XFER, 0, 16'h0000, 24'h000000, 16'h0000, 8'h00));
		request_fifo.push_back(make_request(OP_XFER, 3, 16'hFFFF, 24'hFFFFFF, 16'hFFFF, 8'hFF));
		request_fifo.push_back(make_request(OP_XFER, 1, 16'h8000, 24'h01FFFE, 16'hFFFF, 8'h02));
		request_fifo.push_back(make_request(OP_XFER, 2, 16'h0010, 24'h01FFFF, 16'h0001, 8'h01));
		request_fifo.push_back(make_request(OP_XFER, 0, 16'hFFF0, 24'h020000, 16'hFFFF, 8'h80));
		request_fifo.push_back(make_request(OP_XFER, 1, 16'h1234, 24'h03FFF0, 16'h0008, 8'h02));
		request_fifo.push_back(make_request(OP_XFER, 2, 16'h1234, 24'h03FFF0, 16'h0009, 8'h7F));
		request_fifo.push_back(make_request(OP_FLUSH, 3, 16'hFFFF, 24'hFFFFFF, 16'hFFFF, 8'hFF));
		request_fifo.push_back(make_request(OP_FILL, 2, 16'hABCD, 24'hABCDEF, 16'hFFFF, 8'h01));
		request_fifo.push_back(make_request(OP_FILL, 3, 16'h0000, 24'hFFFFFF, 16'h0000, 8'hC0));
		request_fifo.push_back(make_request(OP_COPY, 1, 16'h1234, 24'hFFFFFF, 16'h8000, 8'h80));
		request_fifo.push_back(make_request(OP_COPY, 3, 16'hFFFF, 24'h000000, 16'h0001, 8'hFF));
		request_fifo.push_back(make_request(OP_FLUSH, 0, 0, 0, 0, 0));
		request_fifo.push_back(make_request(OP_FLUSH, 0, 0, 0, 0, 0));
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i < 150)
				request_fifo.push_back(random_request(8));
			else if (i < 300)
				request_fifo.push_back(random_request(0));
			else
				request_fifo.push_back(random_request(5));
		end
		request_fifo.push_back(make_request(OP_FLUSH, 0, 0, 0, 0, 0));

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		@(posedge clk);
		while (request_fifo.size() > 0 || req_valid)
			@(posedge clk);
		while (expected_cmds.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
`default_nettype wire
